### src/pcpf_pkg.sv
// ----------------------------------------------------------------------------
// Polygon clip particle filter package
// Shared types, widths and codes for the particle filter and its edge pipe.
// ----------------------------------------------------------------------------
package pcpf_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int MAX_KEPT     = 1024;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int VIDX_W   = 4;
   localparam int VCOUNT_W = 5;
   localparam int SLOT_W   = 10;
   localparam int VADDR_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int ISSUE_W  = VCOUNT_W + 1;
   localparam int KEPT_W   = $clog2(MAX_KEPT + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y     = 3'd3;

   localparam logic [1:0] CMD_WRITE_VERTEX  = 2'd0;
   localparam logic [1:0] CMD_START_FRAME   = 2'd1;
   localparam logic [1:0] CMD_TEST_PARTICLE = 2'd2;

   localparam logic [COORD_W-1:0] SCALE_RESET = 32'h0001_0000;

   typedef struct packed {
      logic [1:0]                cmd;
      logic [VIDX_W-1:0]         vertex_index;
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [COORD_W-1:0] top_left_x;
      logic signed [COORD_W-1:0] top_left_y;
      logic signed [COORD_W-1:0] bottom_right_x;
      logic signed [COORD_W-1:0] bottom_right_y;
   } req_type;

   typedef struct packed {
      logic              keep;
      logic [SLOT_W-1:0] out_slot;
      logic              inside_res;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      vertex_type                vi;
      vertex_type                vj;
   } edge_op_type;

   typedef struct packed {
      logic valid;
      logic hit;
      logic busy;
   } edge_res_type;

endpackage

### src/pcpf_edge_pipe.sv
// ----------------------------------------------------------------------------
// Polygon clip particle filter edge pipe
// Three-stage crossing test of one polygon edge per cycle: differences,
// exact products, signed compare.
// ----------------------------------------------------------------------------
module pcpf_edge_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  pcpf_pkg::edge_op_type op,
   output pcpf_pkg::edge_res_type res
);

   logic                                  a_valid_ff, a_valid_in;
   logic                                  a_cross_ff, a_cross_in;
   logic                                  a_dpos_ff, a_dpos_in;
   logic signed [pcpf_pkg::DIFF_W-1:0]    a_dx_ff, a_dx_in;
   logic signed [pcpf_pkg::DIFF_W-1:0]    a_dy_ff, a_dy_in;
   logic signed [pcpf_pkg::DIFF_W-1:0]    a_ex_ff, a_ex_in;
   logic signed [pcpf_pkg::DIFF_W-1:0]    a_ey_ff, a_ey_in;

   logic                                  b_valid_ff;
   logic                                  b_cross_ff;
   logic                                  b_dpos_ff;
   logic signed [pcpf_pkg::PROD_W-1:0]    b_lhs_ff, b_lhs_in;
   logic signed [pcpf_pkg::PROD_W-1:0]    b_rhs_ff, b_rhs_in;

   logic                                  c_valid_ff;
   logic                                  c_hit_ff, c_hit_in;

   always_comb begin
      a_valid_in = op.valid;
      a_cross_in = (op.vi.y >= op.py) != (op.vj.y >= op.py);
      a_dpos_in  = op.vj.y > op.vi.y;
      a_dx_in    = $signed({op.px[pcpf_pkg::COORD_W-1], op.px})
                 - $signed({op.vi.x[pcpf_pkg::COORD_W-1], op.vi.x});
      a_dy_in    = $signed({op.vj.y[pcpf_pkg::COORD_W-1], op.vj.y})
                 - $signed({op.vi.y[pcpf_pkg::COORD_W-1], op.vi.y});
      a_ex_in    = $signed({op.vj.x[pcpf_pkg::COORD_W-1], op.vj.x})
                 - $signed({op.vi.x[pcpf_pkg::COORD_W-1], op.vi.x});
      a_ey_in    = $signed({op.py[pcpf_pkg::COORD_W-1], op.py})
                 - $signed({op.vi.y[pcpf_pkg::COORD_W-1], op.vi.y});
      b_lhs_in   = a_dx_ff * a_dy_ff;
      b_rhs_in   = a_ex_ff * a_ey_ff;
      c_hit_in   = b_cross_ff && (b_dpos_ff ? (b_lhs_ff <= b_rhs_ff) : (b_lhs_ff >= b_rhs_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_cross_ff <= a_cross_in;
      a_dpos_ff  <= a_dpos_in;
      a_dx_ff    <= a_dx_in;
      a_dy_ff    <= a_dy_in;
      a_ex_ff    <= a_ex_in;
      a_ey_ff    <= a_ey_in;
      b_cross_ff <= a_cross_ff;
      b_dpos_ff  <= a_dpos_ff;
      b_lhs_ff   <= b_lhs_in;
      b_rhs_ff   <= b_rhs_in;
      c_hit_ff   <= c_hit_in;
   end

   assign res.valid = c_valid_ff;
   assign res.hit   = c_hit_ff;
   assign res.busy  = a_valid_ff | b_valid_ff | c_valid_ff;

endmodule

### src/polygon_clip_particle_filter_top.sv
// ----------------------------------------------------------------------------
// Polygon clip particle filter
// Stores a polygon in a vertex memory, runs a crossing-number test on each
// particle centre and hands out compacted slots to the particles inside.
// ----------------------------------------------------------------------------
// Vertex writes, frame starts and unused commands are done as they are
// accepted. A test-particle transfer passes these steps, where n is
// vertex_count capped at MAX_VERTICES. The centre is formed, scaled and
// offset. Then n + 1 reads of the vertex memory, once per vertex plus once
// for the closing vertex, feed one edge per cycle into a three-stage compare
// pipe. The last edge is carried through the pipe, its crossing is folded
// into the parity, the pipe is seen empty, and the result is delivered to the
// output register. With no vertices in use the reads and the pipe are skipped.
// The next transfer can be accepted in the cycle after the result is
// registered. The single read port of the vertex memory sets the edge rate.
// The block takes one item at a time; a finished result waits in the output
// register while the next transfer is accepted, and a particle that finishes
// while that result is still stalled waits until the output register is free.
module polygon_clip_particle_filter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pcpf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pcpf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pcpf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pcpf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SCALE,
      ST_POINT,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                                 state_ff;

   logic [pcpf_pkg::VCOUNT_W-1:0]             vertex_count_ff;
   logic [pcpf_pkg::COORD_W-1:0]              scale_factor_ff;
   logic signed [pcpf_pkg::COORD_W-1:0]       offset_x_ff;
   logic signed [pcpf_pkg::COORD_W-1:0]       offset_y_ff;

   pcpf_pkg::vertex_type                      vertex_mem [pcpf_pkg::MAX_VERTICES];
   pcpf_pkg::vertex_type                      rd_data_ff;
   pcpf_pkg::vertex_type                      prev_ff;
   logic                                      rd_edge_ff;
   logic                                      rd_prev_ff;
   logic [pcpf_pkg::ISSUE_W-1:0]              issue_ff;
   logic                                      mem_we;
   logic                                      mem_re;
   logic [pcpf_pkg::VADDR_W-1:0]              rd_addr;

   pcpf_pkg::req_type                         item_ff;
   logic signed [pcpf_pkg::COORD_W-1:0]       cx_ff, cx_in;
   logic signed [pcpf_pkg::COORD_W-1:0]       cy_ff, cy_in;
   logic signed [pcpf_pkg::COORD_W:0]         sum_x;
   logic signed [pcpf_pkg::COORD_W:0]         sum_y;
   logic signed [2*pcpf_pkg::COORD_W:0]       prod_x_ff, prod_x_in;
   logic signed [2*pcpf_pkg::COORD_W:0]       prod_y_ff, prod_y_in;
   logic signed [pcpf_pkg::COORD_W-1:0]       px_ff, px_in;
   logic signed [pcpf_pkg::COORD_W-1:0]       py_ff, py_in;

   logic                                      inside_ff;
   logic [pcpf_pkg::KEPT_W-1:0]               kept_count_ff;
   logic                                      rsp_valid_ff;
   pcpf_pkg::rsp_type                         rsp_ff;
   logic                                      keep;

   logic [pcpf_pkg::VCOUNT_W-1:0]             n_eff;
   logic                                      issue_left;
   logic                                      req_fire;
   logic                                      rsp_free;

   pcpf_pkg::edge_op_type                     edge_op;
   pcpf_pkg::edge_res_type                    edge_res;

   function automatic logic signed [pcpf_pkg::COORD_W-1:0] scale_offset(
      input logic signed [2*pcpf_pkg::COORD_W:0]   prod,
      input logic signed [pcpf_pkg::COORD_W-1:0]   offset
   );
      logic signed [2*pcpf_pkg::COORD_W-15:0] total;
      total = $signed(prod[2*pcpf_pkg::COORD_W:16])
            + $signed({{(pcpf_pkg::COORD_W-15){offset[pcpf_pkg::COORD_W-1]}}, offset});
      if (total > $signed({{(pcpf_pkg::COORD_W-14){1'b0}}, {(pcpf_pkg::COORD_W-1){1'b1}}})) begin
         scale_offset = {1'b0, {(pcpf_pkg::COORD_W-1){1'b1}}};
      end else if (total < $signed({{(pcpf_pkg::COORD_W-14){1'b1}},
                                    {(pcpf_pkg::COORD_W-1){1'b0}}})) begin
         scale_offset = {1'b1, {(pcpf_pkg::COORD_W-1){1'b0}}};
      end else begin
         scale_offset = total[pcpf_pkg::COORD_W-1:0];
      end
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      n_eff = (32'(vertex_count_ff) > pcpf_pkg::MAX_VERTICES)
            ? pcpf_pkg::VCOUNT_W'(pcpf_pkg::MAX_VERTICES) : vertex_count_ff;
      issue_left = issue_ff <= pcpf_pkg::ISSUE_W'(n_eff);
      mem_re     = (state_ff == ST_RUN) && issue_left;
      rd_addr    = (issue_ff == '0) ? pcpf_pkg::VADDR_W'(n_eff - 1'b1)
                                    : pcpf_pkg::VADDR_W'(issue_ff - 1'b1);
      mem_we     = req_fire && (req_data.cmd == pcpf_pkg::CMD_WRITE_VERTEX)
                && (32'(req_data.vertex_index) < pcpf_pkg::MAX_VERTICES);
      keep       = inside_ff && (kept_count_ff < pcpf_pkg::KEPT_W'(pcpf_pkg::MAX_KEPT));

      sum_x = $signed({item_ff.top_left_x[pcpf_pkg::COORD_W-1], item_ff.top_left_x})
            + $signed({item_ff.bottom_right_x[pcpf_pkg::COORD_W-1], item_ff.bottom_right_x});
      sum_y = $signed({item_ff.top_left_y[pcpf_pkg::COORD_W-1], item_ff.top_left_y})
            + $signed({item_ff.bottom_right_y[pcpf_pkg::COORD_W-1], item_ff.bottom_right_y});
      cx_in = sum_x[pcpf_pkg::COORD_W:1];
      cy_in = sum_y[pcpf_pkg::COORD_W:1];
      prod_x_in = cx_ff * $signed({1'b0, scale_factor_ff});
      prod_y_in = cy_ff * $signed({1'b0, scale_factor_ff});
      px_in = scale_offset(prod_x_ff, offset_x_ff);
      py_in = scale_offset(prod_y_ff, offset_y_ff);

      edge_op.valid = rd_edge_ff;
      edge_op.px    = px_ff;
      edge_op.py    = py_ff;
      edge_op.vi    = rd_data_ff;
      edge_op.vj    = prev_ff;
   end

   pcpf_edge_pipe u_edge_pipe (
      .clock (clock),
      .reset (reset),
      .op    (edge_op),
      .res   (edge_res)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vertex_mem[pcpf_pkg::VADDR_W'(req_data.vertex_index)] <=
            '{x: req_data.vertex_x, y: req_data.vertex_y};
      end
      if (mem_re) begin
         rd_data_ff <= vertex_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
      end
      if (rd_edge_ff || rd_prev_ff) begin
         prev_ff <= rd_data_ff;
      end
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      if (state_ff == ST_POINT) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         scale_factor_ff <= pcpf_pkg::SCALE_RESET;
         offset_x_ff     <= '0;
         offset_y_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pcpf_pkg::CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata[pcpf_pkg::VCOUNT_W-1:0];
            pcpf_pkg::CSR_SCALE_FACTOR: scale_factor_ff <= csr_wdata;
            pcpf_pkg::CSR_OFFSET_X:     offset_x_ff     <= $signed(csr_wdata);
            pcpf_pkg::CSR_OFFSET_Y:     offset_y_ff     <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= '0;
         rd_edge_ff    <= 1'b0;
         rd_prev_ff    <= 1'b0;
         inside_ff     <= 1'b0;
         kept_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_edge_ff <= mem_re && (issue_ff != '0);
         rd_prev_ff <= mem_re && (issue_ff == '0);
         if (edge_res.valid && edge_res.hit) begin
            inside_ff <= !inside_ff;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_data.cmd == pcpf_pkg::CMD_START_FRAME) begin
                     kept_count_ff <= '0;
                  end
                  if (req_data.cmd == pcpf_pkg::CMD_TEST_PARTICLE) begin
                     state_ff <= ST_CENTER;
                  end
               end
            end
            ST_CENTER: begin
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               state_ff <= ST_POINT;
            end
            ST_POINT: begin
               inside_ff <= 1'b0;
               issue_ff  <= '0;
               state_ff  <= (n_eff == '0) ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
               if (issue_left) begin
                  issue_ff <= issue_ff + 1'b1;
               end else if (!rd_edge_ff && !rd_prev_ff && !edge_res.busy) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.keep         <= keep;
                  rsp_ff.out_slot     <= keep ? pcpf_pkg::SLOT_W'(kept_count_ff) : '0;
                  rsp_ff.inside_res   <= inside_ff;
                  if (keep) begin
                     kept_count_ff <= kept_count_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### sim/polygon_clip_particle_filter_top_test.sv
// ----------------------------------------------------------------------------
// Polygon clip particle filter testbench
// Loads polygons through the request channel, sets scale and offset through
// the register port, and sends particles with directed and random corners.
// An in-order predictor of the crossing-number test and of the slot counter
// checks every result transfer, field by field, as it is accepted.
// ----------------------------------------------------------------------------
module polygon_clip_particle_filter_top_test;

   import pcpf_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE  = 3'd6;
   localparam logic [1:0]             CMD_UNUSED = 2'd3;
   localparam logic [COORD_W-1:0]     SCALE_DOUBLE = 32'h0002_0000;
   localparam longint COORD_MAX     = 64'sh0000_0000_7FFF_FFFF;
   localparam longint COORD_MIN     = -COORD_MAX - 1;
   localparam int     IDLE_PCT      = 11;
   localparam int     SETTLE_CYCLES = 40;
   localparam int     QUIET_LIMIT   = 2000;
   localparam int     SQUARE_HALF   = 1 << 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predicted state of the filter.
   longint                    poly_x [MAX_VERTICES];
   longint                    poly_y [MAX_VERTICES];
   int                        kept_slots = 0;
   logic [VCOUNT_W-1:0]       vcount_model = '0;
   logic [COORD_W-1:0]        scale_model = SCALE_RESET;
   logic signed [COORD_W-1:0] off_x_model = '0;
   logic signed [COORD_W-1:0] off_y_model = '0;

   rsp_type pending_filter_results [$];
   rsp_type expected_rsp;
   int      mismatch_count = 0;
   int      quiet_cycles = 0;
   bit      idling_on = 1'b1;
   int      spread_bits = 20;

   polygon_clip_particle_filter_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic signed [COORD_W-1:0] place_coord(
      logic signed [COORD_W-1:0] lo, logic signed [COORD_W-1:0] hi,
      logic signed [COORD_W-1:0] offset);
      longint centre;
      longint placed;
      centre = (longint'(lo) + longint'(hi)) >>> 1;
      placed = ((centre * longint'(scale_model)) >>> 16) + longint'(offset);
      if (placed > COORD_MAX) placed = COORD_MAX;
      if (placed < COORD_MIN) placed = COORD_MIN;
      return COORD_W'(placed);
   endfunction

   function automatic bit edge_crossed(longint px, longint py, longint xi, longint yi,
                                       longint xj, longint yj);
      logic signed [71:0] run;
      logic signed [71:0] rise;
      logic signed [71:0] lhs;
      logic signed [71:0] rhs;
      if ((yi >= py) == (yj >= py)) return 1'b0;
      run  = px - xi;
      rise = yj - yi;
      lhs  = run * rise;
      rhs  = (xj - xi) * (py - yi);
      return (rise > 0) ? (lhs <= rhs) : (lhs >= rhs);
   endfunction

   function automatic int active_vertices();
      return (vcount_model > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_model);
   endfunction

   function automatic bit point_in_polygon(longint px, longint py);
      int count;
      int j;
      bit odd;
      count = active_vertices();
      odd = 1'b0;
      for (int i = 0; i < count; i++) begin
         j = (i == 0) ? count - 1 : i - 1;
         if (edge_crossed(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j])) odd = !odd;
      end
      return odd;
   endfunction

   function automatic void predict_item(req_type item);
      rsp_type result;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      case (item.cmd)
         CMD_WRITE_VERTEX: begin
            poly_x[item.vertex_index] = longint'(item.vertex_x);
            poly_y[item.vertex_index] = longint'(item.vertex_y);
         end
         CMD_START_FRAME: kept_slots = 0;
         CMD_TEST_PARTICLE: begin
            px = place_coord(item.top_left_x, item.bottom_right_x, off_x_model);
            py = place_coord(item.top_left_y, item.bottom_right_y, off_y_model);
            result.inside_res = point_in_polygon(longint'(px), longint'(py));
            result.keep = result.inside_res && (kept_slots < MAX_KEPT);
            result.out_slot = '0;
            if (result.keep) begin
               result.out_slot = SLOT_W'(kept_slots);
               kept_slots++;
            end
            pending_filter_results.push_back(result);
         end
         default: ;
      endcase
   endfunction

   function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch on %s: expected %0h, actual %0h", field, want, got);
   endfunction

   function automatic longint random_span(int bits);
      if (bits >= 31) return longint'(int'($urandom));
      return longint'($urandom_range(0, 32'd1 << (bits + 1))) - (longint'(1) << bits);
   endfunction

   function automatic req_type random_req(logic [1:0] cmd);
      req_type item;
      item.cmd            = cmd;
      item.vertex_index   = VIDX_W'($urandom);
      item.vertex_x       = $urandom;
      item.vertex_y       = $urandom;
      item.top_left_x     = $urandom;
      item.top_left_y     = $urandom;
      item.bottom_right_x = $urandom;
      item.bottom_right_y = $urandom;
      return item;
   endfunction

   function automatic req_type aim_particle(longint tx, longint ty);
      req_type item;
      longint cx;
      longint cy;
      longint rx;
      longint ry;
      item = random_req(CMD_TEST_PARTICLE);
      cx = tx - longint'(off_x_model);
      cy = ty - longint'(off_y_model);
      if (scale_model == SCALE_DOUBLE) begin
         cx = cx >>> 1;
         cy = cy >>> 1;
      end
      rx = $urandom_range(0, 32'd1 << ((spread_bits > 28) ? 28 : spread_bits));
      ry = $urandom_range(0, 32'd1 << ((spread_bits > 28) ? 28 : spread_bits));
      item.top_left_x     = COORD_W'(cx - rx);
      item.top_left_y     = COORD_W'(cy - ry);
      item.bottom_right_x = COORD_W'(cx + rx + $urandom_range(0, 1));
      item.bottom_right_y = COORD_W'(cy + ry + $urandom_range(0, 1));
      return item;
   endfunction

   function automatic void pick_target(output longint tx, output longint ty);
      int count;
      int i;
      int j;
      int pick;
      count = active_vertices();
      pick = $urandom_range(0, 9);
      if (count > 0 && pick == 0) begin
         i = $urandom_range(0, count - 1);
         tx = poly_x[i];
         ty = poly_y[i];
      end else if (count > 0 && pick == 1) begin
         i = $urandom_range(0, count - 1);
         j = (i == 0) ? count - 1 : i - 1;
         tx = (poly_x[i] + poly_x[j]) >>> 1;
         ty = (poly_y[i] + poly_y[j]) >>> 1;
      end else begin
         tx = random_span((spread_bits > 28) ? 29 : spread_bits + 1);
         ty = random_span((spread_bits > 28) ? 29 : spread_bits + 1);
      end
   endfunction

   task automatic send_item(input req_type item);
      while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(item);
      @(negedge clock);
   endtask

   task automatic send_particle(input longint tlx, input longint tly,
                                input longint brx, input longint bry);
      req_type item;
      item = random_req(CMD_TEST_PARTICLE);
      item.top_left_x     = COORD_W'(tlx);
      item.top_left_y     = COORD_W'(tly);
      item.bottom_right_x = COORD_W'(brx);
      item.bottom_right_y = COORD_W'(bry);
      send_item(item);
   endtask

   task automatic write_vertex(input int index, input longint x, input longint y);
      req_type item;
      item = random_req(CMD_WRITE_VERTEX);
      item.vertex_index = VIDX_W'(index);
      item.vertex_x     = COORD_W'(x);
      item.vertex_y     = COORD_W'(y);
      send_item(item);
   endtask

   // Waits until every expected result has arrived and the last item has left.
   task automatic drain_filter();
      req_valid <= 1'b0;
      while (pending_filter_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_VERTEX_COUNT: vcount_model = value[VCOUNT_W-1:0];
         CSR_SCALE_FACTOR: scale_model  = value;
         CSR_OFFSET_X:     off_x_model  = value;
         CSR_OFFSET_Y:     off_y_model  = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_filter_config(input logic [CSR_DATA_W-1:0] vcount,
                                    input logic [CSR_DATA_W-1:0] scale,
                                    input logic [CSR_DATA_W-1:0] ox,
                                    input logic [CSR_DATA_W-1:0] oy);
      drain_filter();
      write_csr(CSR_VERTEX_COUNT, vcount);
      write_csr(CSR_SCALE_FACTOR, scale);
      write_csr(CSR_OFFSET_X, ox);
      write_csr(CSR_OFFSET_Y, oy);
      csr_valid <= 1'b0;
   endtask

   task automatic load_polygon(input int bits, input bit rectangle);
      longint half_x;
      longint half_y;
      half_x = (bits >= 31) ? COORD_MAX : (longint'(1) << bits) + $urandom_range(0, 255);
      half_y = (bits >= 31) ? COORD_MIN : (longint'(1) << bits) - $urandom_range(0, 255);
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (rectangle && i < 4)
            write_vertex(i, (i == 0 || i == 3) ? -half_x : half_x,
                         (i < 2) ? -half_y : half_y);
         else
            write_vertex(i, random_span(bits), random_span(bits));
      end
   endtask

   task automatic run_mixed_traffic(input int count);
      req_type item;
      longint tx;
      longint ty;
      int sel;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            pick_target(tx, ty);
            item = aim_particle(tx, ty);
         end else if (sel < 80) begin
            item = random_req(CMD_TEST_PARTICLE);
         end else if (sel < 87) begin
            item = random_req(CMD_START_FRAME);
         end else if (sel < 95) begin
            item = random_req(CMD_WRITE_VERTEX);
            if ($urandom_range(0, 3) != 0) begin
               item.vertex_x = COORD_W'(random_span(spread_bits));
               item.vertex_y = COORD_W'(random_span(spread_bits));
            end
         end else begin
            item = random_req(CMD_UNUSED);
         end
         send_item(item);
      end
   endtask

   // The filter comes out of reset with no vertices in use, so nothing is inside.
   task automatic test_reset_state();
      send_item(random_req(CMD_TEST_PARTICLE));
      send_item(random_req(CMD_UNUSED));
      send_item(random_req(CMD_START_FRAME));
   endtask

   task automatic test_polygon_load();
      write_vertex(0, -SQUARE_HALF, -SQUARE_HALF);
      write_vertex(1,  SQUARE_HALF, -SQUARE_HALF);
      write_vertex(2,  SQUARE_HALF,  SQUARE_HALF);
      write_vertex(3, -SQUARE_HALF,  SQUARE_HALF);
      for (int i = 4; i < MAX_VERTICES - 2; i++)
         write_vertex(i, random_span(22), random_span(22));
      write_vertex(MAX_VERTICES - 2, COORD_MIN, COORD_MAX);
      write_vertex(MAX_VERTICES - 1, COORD_MAX, COORD_MIN);
   endtask

   task automatic test_square_particles();
      set_filter_config(4, SCALE_RESET, 0, 0);
      write_csr(CSR_SPARE, $urandom);
      csr_valid <= 1'b0;
      send_particle(-10, -10, 10, 10);
      send_particle(2 * SQUARE_HALF, 0, 2 * SQUARE_HALF, 0);
      send_particle(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_particle(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_particle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_particle(SQUARE_HALF, SQUARE_HALF, SQUARE_HALF, SQUARE_HALF);
      send_particle(-SQUARE_HALF, 0, -SQUARE_HALF, 1);
   endtask

   task automatic test_vertex_count_limits();
      set_filter_config(1, SCALE_RESET, 0, 0);
      send_particle(-10, -10, 10, 10);
      set_filter_config(2, SCALE_RESET, 0, 0);
      send_particle(-10, -10, 10, 10);
      set_filter_config(31, SCALE_RESET, 0, 0);
      send_particle(-10, -10, 10, 10);
   endtask

   // With a zero scale every particle lands on the offset, which lies inside
   // the triangle, so the slot counter runs up to its limit and then holds.
   task automatic test_slot_saturation();
      idling_on = 1'b0;
      set_filter_config(3, 0, 5, 7);
      write_vertex(0, -(1 <<< 24), -(1 <<< 24));
      write_vertex(1,  (1 <<< 24), -(1 <<< 24));
      write_vertex(2, 0, 1 <<< 24);
      send_item(random_req(CMD_START_FRAME));
      for (int k = 0; k < MAX_KEPT + 6; k++)
         send_item(random_req(CMD_TEST_PARTICLE));
      send_item(random_req(CMD_START_FRAME));
      for (int k = 0; k < 3; k++)
         send_item(random_req(CMD_TEST_PARTICLE));
      idling_on = 1'b1;
   endtask

   task automatic test_random_phases();
      logic [CSR_DATA_W-1:0] vcount;
      logic [CSR_DATA_W-1:0] scale;
      logic [CSR_DATA_W-1:0] ox;
      logic [CSR_DATA_W-1:0] oy;
      bit rectangle;
      for (int phase = 0; phase < 14; phase++) begin
         spread_bits = $urandom_range(8, 28);
         rectangle = $urandom_range(0, 1);
         scale = SCALE_RESET;
         ox = COORD_W'(random_span(spread_bits));
         oy = COORD_W'(random_span(spread_bits));
         vcount = $urandom_range(3, MAX_VERTICES);
         case (phase)
            0: begin
               vcount = 4;
               ox = '0;
               oy = '0;
               rectangle = 1'b1;
            end
            1: vcount = MAX_VERTICES;
            2: begin
               vcount = 3;
               scale = SCALE_DOUBLE;
            end
            3: vcount = 31;
            4: vcount = 0;
            5: vcount = 1;
            6: vcount = 2;
            7: begin
               vcount = MAX_VERTICES;
               scale = 32'hFFFF_FFFF;
               ox = 32'h7FFF_FFFF;
               oy = 32'h8000_0000;
               spread_bits = 31;
            end
            8: begin
               vcount = 5;
               scale = '0;
               ox = 32'h8000_0000;
               oy = 32'h7FFF_FFFF;
               spread_bits = 31;
            end
            9: begin
               vcount = 8;
               scale = $urandom;
               ox = $urandom;
               oy = $urandom;
            end
            default: ;
         endcase
         set_filter_config(vcount, scale, ox, oy);
         load_polygon(spread_bits, rectangle);
         run_mixed_traffic(26);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= idling_on && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_filter_results.size() == 0) begin
            flag_mismatch("unexpected result transfer", '0, 32'(rsp_data));
         end else begin
            expected_rsp = pending_filter_results.pop_front();
            if (rsp_data.keep !== expected_rsp.keep)
               flag_mismatch("keep", expected_rsp.keep, rsp_data.keep);
            if (rsp_data.out_slot !== expected_rsp.out_slot)
               flag_mismatch("out_slot", expected_rsp.out_slot, rsp_data.out_slot);
            if (rsp_data.inside_res !== expected_rsp.inside_res)
               flag_mismatch("inside_res", expected_rsp.inside_res, rsp_data.inside_res);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_polygon_load();
      test_square_particles();
      test_vertex_count_limits();
      test_slot_saturation();
      test_random_phases();
      drain_filter();
      if (mismatch_count == 0 && pending_filter_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
